### rtl/ktk_pkg.sv
`default_nettype none

package ktk_pkg;

    // table geometry and field widths
    localparam int DEPTH       = 10;
    localparam int KEY_BITS    = 16;
    localparam int SCORE_BITS  = 24;
    localparam int STATUS_BITS = 2;
    localparam int RANK_BITS   = 4;
    // wide enough to hold every position plus the not-held code DEPTH
    localparam int RANK_W      = $clog2(DEPTH + 1);

    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [SCORE_BITS-1:0] score_t;
    typedef logic [RANK_W-1:0]     rank_t;
    typedef logic [DEPTH-1:0]      row_t;

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_INSERTED  = 2'd0,
        ST_RAISED    = 2'd1,
        ST_UNCHANGED = 2'd2,
        ST_REJECTED  = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY
    } state_t;

    // contents of one cell, handed to the next cell down
    typedef struct packed {
        logic   valid;
        key_t   key;
        score_t score;
    } entry_t;

    // per-cell update command
    typedef struct packed {
        logic take_new;
        logic shift;
    } cell_ctrl_t;

    // position of the set bit of a one-hot row, zero when the row is empty
    function automatic rank_t onehot_index(row_t v);
        rank_t r;
        r = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (v[i])
            begin
                r = r | rank_t'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/ktk_in_if.sv
`default_nettype none

interface ktk_in_if;
    import ktk_pkg::*;

    logic   valid;
    logic   ready;
    key_t   player_key;
    score_t new_score;

    modport source (output valid, output player_key, output new_score, input ready);
    modport sink   (input valid, input player_key, input new_score, output ready);
endinterface

`default_nettype wire

### rtl/ktk_out_if.sv
`default_nettype none

interface ktk_out_if;
    import ktk_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [RANK_BITS-1:0]   rank;

    modport source (output valid, output status, output rank, input ready);
    modport sink   (input valid, input status, input rank, output ready);
endinterface

`default_nettype wire

### rtl/ktk_cell.sv
`default_nettype none

module ktk_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ktk_pkg::key_t       probe_key,
    input  wire ktk_pkg::score_t     probe_score,
    input  wire ktk_pkg::entry_t     prev_entry,
    input  wire ktk_pkg::cell_ctrl_t ctrl,
    output ktk_pkg::entry_t          cur_entry,
    output logic                     match,
    output logic                     ge
);
    import ktk_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    key_t   key_reg;
    key_t   key_next;
    score_t score_reg;
    score_t score_next;

    // compare stored entry against the probe
    assign match = valid_reg && (key_reg == probe_key);
    assign ge    = valid_reg && (score_reg >= probe_score);

    // take the probe, take the neighbor above, or hold
    always_comb
    begin
        priority if (ctrl.take_new)
        begin
            valid_next = 1'b1;
            key_next   = probe_key;
            score_next = probe_score;
        end
        else if (ctrl.shift)
        begin
            valid_next = prev_entry.valid;
            key_next   = prev_entry.key;
            score_next = prev_entry.score;
        end
        else
        begin
            valid_next = valid_reg;
            key_next   = key_reg;
            score_next = score_reg;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // key and score storage
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        score_reg <= score_next;
    end

    assign cur_entry = '{valid: valid_reg, key: key_reg, score: score_reg};

endmodule

`default_nettype wire

### rtl/keyed_top_k_score_table.sv
`default_nettype none

// Keyed top-K score table: holds up to ktk_pkg::DEPTH key/score entries in
// descending score order in a row of cells. Each transfer on in_ch offers a
// key and a score and yields one transfer on out_ch with a status and the
// key's final rank. Each item passes an evaluate state, in which every cell
// compares its entry against the offered key and score, then an apply state,
// in which the row shifts by one place where needed and the result is
// registered; the next item is accepted as the apply state fires. The cell
// update waits while a previous result has not been taken.
module keyed_top_k_score_table (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ktk_in_if.sink     in_ch,
    ktk_out_if.source  out_ch
);
    import ktk_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    key_t       probe_key_reg;
    score_t     probe_score_reg;
    row_t       match_reg;
    row_t       ge_reg;
    logic       out_valid_reg;
    status_t    status_reg;
    status_t    status_next;
    rank_t      rank_reg;
    rank_t      rank_next;

    logic       in_xfer;
    logic       advance;
    logic       apply_fire;
    logic       do_raise;
    logic       do_insert;
    row_t       match_row;
    row_t       ge_row;
    row_t       valid_row;
    row_t       boundary;
    entry_t     entries [DEPTH];
    cell_ctrl_t ctrls   [DEPTH];
    logic [RANK_W+RANK_BITS-1:0] rank_ext;

    // handshake
    assign advance    = !out_valid_reg || out_ch.ready;
    assign apply_fire = (state_reg == S_APPLY) && advance;
    assign in_ch.ready = (state_reg == S_IDLE) || apply_fire;
    assign in_xfer    = in_ch.valid && in_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = in_xfer ? S_EVAL : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // probe latch and compare flags
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            probe_key_reg   <= in_ch.player_key;
            probe_score_reg <= in_ch.new_score;
        end
        if (state_reg == S_EVAL)
        begin
            match_reg <= match_row;
            ge_reg    <= ge_row;
        end
    end

    // insertion point: first cell that is empty or scores below the probe
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
            begin
                boundary[i] = !ge_reg[i];
            end
            else
            begin
                boundary[i] = ge_reg[i-1] && !ge_reg[i];
            end
        end
    end

    // decode the operation and the result
    always_comb
    begin
        do_raise    = 1'b0;
        do_insert   = 1'b0;
        priority if (|(match_reg & ge_reg))
        begin
            status_next = ST_UNCHANGED;
            rank_next   = onehot_index(match_reg);
        end
        else if (|match_reg)
        begin
            do_raise    = 1'b1;
            status_next = ST_RAISED;
            rank_next   = onehot_index(boundary);
        end
        else if (|boundary)
        begin
            do_insert   = 1'b1;
            status_next = ST_INSERTED;
            rank_next   = onehot_index(boundary);
        end
        else
        begin
            status_next = ST_REJECTED;
            rank_next   = rank_t'(DEPTH);
        end
    end

    // row of cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        entry_t prev_entry;
        logic   upto_match;

        // cell sits at or above the matched entry
        assign upto_match = |(match_reg >> g);

        if (g == 0)
        begin : g_head
            assign prev_entry = '0;
            assign ctrls[g].shift = 1'b0;
        end
        else
        begin : g_body
            assign prev_entry = entries[g-1];
            assign ctrls[g].shift = apply_fire && !ge_reg[g-1]
                                  && (do_insert || (do_raise && upto_match));
        end
        assign ctrls[g].take_new = apply_fire && boundary[g] && (do_insert || do_raise);

        ktk_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .probe_key   (probe_key_reg),
            .probe_score (probe_score_reg),
            .prev_entry  (prev_entry),
            .ctrl        (ctrls[g]),
            .cur_entry   (entries[g]),
            .match       (match_row[g]),
            .ge          (ge_row[g])
        );

        assign valid_row[g] = entries[g].valid;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (apply_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply_fire)
        begin
            status_reg <= status_next;
            rank_reg   <= rank_next;
        end
    end

    assign rank_ext      = {{RANK_BITS{1'b0}}, rank_reg};
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.status = status_reg;
    assign out_ch.rank   = rank_ext[RANK_BITS-1:0];

    // checks
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_EVAL))
        else $error("accepted item did not enter compare cycle");

    a_ge_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> ((ge_reg & (ge_reg + row_t'(1))) == '0))
        else $error("score compare flags are not a prefix");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(match_reg))
        else $error("key held in more than one cell");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_row & (valid_row + row_t'(1))) == '0)
        else $error("valid entries do not form a prefix");

endmodule

`default_nettype wire

### tb/tb_keyed_top_k_score_table.sv
`timescale 1ns / 100ps

module tb_keyed_top_k_score_table;
    import ktk_pkg::*;

    localparam int NUM_DIRECTED = 20;
    localparam int RANDOM_ITEMS = 1850;
    localparam int POOL_SIZE    = 24;
    localparam int SCORE_STEP   = 9000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_AT      = 420;
    localparam int HOLD_CYCLES  = 200;

    typedef logic [RANK_BITS-1:0] rank_field_t;

    // one offered score, with an optional typed-in outcome
    typedef struct packed {
        key_t        key;
        score_t      score;
        logic        pinned;
        status_t     st;
        rank_field_t rk;
    } score_row_t;

    // outcome of one transfer on the result side
    typedef struct packed {
        status_t     st;
        rank_field_t rk;
    } verdict_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_CYCLIC
    } sink_mode_t;

    localparam rank_field_t NOT_HELD = rank_field_t'(DEPTH);

    // directed rows: empty table, extremes, equal scores, full table, drop-out
    localparam score_row_t DIRECTED [NUM_DIRECTED] = '{
        '{16'h0000, 24'h000000, 1'b1, ST_INSERTED,  4'd0},
        '{16'hFFFF, 24'hFFFFFF, 1'b1, ST_INSERTED,  4'd0},
        '{16'hFFFF, 24'hFFFFFF, 1'b1, ST_UNCHANGED, 4'd0},
        '{16'h0000, 24'h000000, 1'b1, ST_UNCHANGED, 4'd1},
        '{16'h1234, 24'h000005, 1'b0, ST_INSERTED,  4'd0},
        '{16'h0000, 24'h000005, 1'b0, ST_INSERTED,  4'd0},
        '{16'h0000, 24'h000003, 1'b0, ST_INSERTED,  4'd0},
        '{16'h5678, 24'h000005, 1'b0, ST_INSERTED,  4'd0},
        '{16'h0100, 24'h000001, 1'b0, ST_INSERTED,  4'd0},
        '{16'h0101, 24'h000001, 1'b0, ST_INSERTED,  4'd0},
        '{16'h0102, 24'h000001, 1'b0, ST_INSERTED,  4'd0},
        '{16'h0103, 24'h000001, 1'b0, ST_INSERTED,  4'd0},
        '{16'h0104, 24'h000001, 1'b0, ST_INSERTED,  4'd0},
        '{16'h0105, 24'h000001, 1'b0, ST_INSERTED,  4'd0},
        '{16'h0200, 24'h000001, 1'b1, ST_REJECTED,  NOT_HELD},
        '{16'h0201, 24'h000000, 1'b1, ST_REJECTED,  NOT_HELD},
        '{16'h0202, 24'h000002, 1'b0, ST_INSERTED,  4'd0},
        '{16'h0101, 24'hFFFFFF, 1'b0, ST_INSERTED,  4'd0},
        '{16'h0105, 24'h000001, 1'b1, ST_REJECTED,  NOT_HELD},
        '{16'hFFFF, 24'h000000, 1'b1, ST_UNCHANGED, 4'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    ktk_in_if  in_ch ();
    ktk_out_if out_ch ();

    keyed_top_k_score_table uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predicted table contents, best score first
    key_t   board_key   [DEPTH];
    score_t board_score [DEPTH];
    bit     board_used  [DEPTH];

    verdict_t awaited_ranks [$];
    int       scores_taken = 0;
    int       bad_results  = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // number of entries held, always a prefix of the table
    function automatic int held_entries();
        int n;
        n = 0;
        while (n < DEPTH && board_used[n])
            n++;
        return n;
    endfunction

    // apply one offered score to the predicted table
    function automatic void apply_score(input key_t k, input score_t s,
                                        output status_t st, output rank_field_t rk);
        int n;
        int p;
        int j;
        n = held_entries();
        // held key: only a strictly higher score moves it up
        for (j = 0; j < n; j++)
        begin
            if (board_key[j] == k)
            begin
                if (s <= board_score[j])
                begin
                    st = ST_UNCHANGED;
                    rk = rank_field_t'(j);
                    return;
                end
                p = j;
                while (p > 0 && board_score[p-1] < s)
                begin
                    board_key[p]   = board_key[p-1];
                    board_score[p] = board_score[p-1];
                    p--;
                end
                board_key[p]   = k;
                board_score[p] = s;
                st = ST_RAISED;
                rk = rank_field_t'(p);
                return;
            end
        end
        // new key goes behind every entry scoring greater or equal
        p = 0;
        while (p < n && board_score[p] >= s)
            p++;
        if (p >= DEPTH)
        begin
            st = ST_REJECTED;
            rk = NOT_HELD;
            return;
        end
        j = (n < DEPTH) ? n : DEPTH - 1;
        while (j > p)
        begin
            board_key[j]   = board_key[j-1];
            board_score[j] = board_score[j-1];
            board_used[j]  = 1'b1;
            j--;
        end
        board_key[p]   = k;
        board_score[p] = s;
        board_used[p]  = 1'b1;
        st = ST_INSERTED;
        rk = rank_field_t'(p);
    endfunction

    // hold one score on the input until its transfer, then record the outcome
    task automatic offer_score(input score_row_t row);
        status_t     st;
        rank_field_t rk;
        verdict_t    v;
        in_ch.valid      <= 1'b1;
        in_ch.player_key <= row.key;
        in_ch.new_score  <= row.score;
        do
            @(posedge clk);
        while (!in_ch.ready);
        apply_score(row.key, row.score, st, rk);
        v.st = st;
        v.rk = rk;
        if (row.pinned)
        begin
            v.st = row.st;
            v.rk = row.rk;
        end
        awaited_ranks.push_back(v);
        scores_taken++;
    endtask

    // input side: reset, directed rows, then random bursts
    initial
    begin : score_source
        key_t       key_pool [POOL_SIZE];
        score_row_t row;
        int         i;
        int         n;
        int         base;
        int         pick;
        int         gap;
        int         burst_left;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.player_key = '0;
        in_ch.new_score  = '0;
        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = key_t'($urandom);
        key_pool[0] = '0;
        key_pool[1] = '1;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_DIRECTED + RANDOM_ITEMS; i++)
        begin
            // gap after each burst, none while the receiver is held off
            if (burst_left == 0)
            begin
                gap = (i >= HOLD_AT - 20 && i < HOLD_AT + 120) ? 0 : $urandom_range(0, 6);
                if (gap > 0)
                begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48)
                                                         : $urandom_range(1, 8);
            end
            burst_left--;

            if (i < NUM_DIRECTED)
            begin
                row = DIRECTED[i];
            end
            else
            begin
                // rising score floor keeps the table churning
                n    = held_entries();
                base = (i - NUM_DIRECTED) * SCORE_STEP;
                pick = $urandom_range(0, 99);
                if (pick < 35 && n > 0)
                    row.key = board_key[$urandom_range(0, n - 1)];
                else if (pick < 75)
                    row.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    row.key = key_t'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 15 && n > 0)
                    row.score = board_score[$urandom_range(0, n - 1)];
                else if (pick < 25)
                    row.score = score_t'($urandom);
                else if (pick < 40)
                    row.score = score_t'($urandom_range(0, base));
                else
                    row.score = score_t'(base + $urandom_range(0, 7));
                row.pinned = 1'b0;
                row.st     = ST_INSERTED;
                row.rk     = '0;
            end
            offer_score(row);
        end
        in_ch.valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (awaited_ranks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_ranks.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, awaited_ranks.size());
            bad_results++;
        end
        if (bad_results == 0)
            $display("keyed_top_k_score_table: match");
        else
            $display("keyed_top_k_score_table: mismatch");
        $finish;
    end

    // result side: check each transfer and stall on a pattern of its own
    initial
    begin : rank_sink
        verdict_t   v;
        sink_mode_t mode;
        int         cyc;
        int         hold_left;
        bit         hold_done;
        out_ch.ready = 1'b0;
        mode      = SINK_OPEN;
        cyc       = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (awaited_ranks.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d rank %0d",
                             $time, out_ch.status, out_ch.rank);
                    bad_results++;
                end
                else
                begin
                    v = awaited_ranks.pop_front();
                    if (out_ch.status !== v.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, v.st, out_ch.status);
                        bad_results++;
                    end
                    if (out_ch.rank !== v.rk)
                    begin
                        $display("%0t: rank expected %0d actual %0d",
                                 $time, v.rk, out_ch.rank);
                        bad_results++;
                    end
                end
            end

            // one long hold-off so the block backs up into its input
            if (!hold_done && scores_taken >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (cyc % 64 == 0)
                mode = sink_mode_t'($urandom_range(0, 3));
            cyc++;

            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_OPEN:   out_ch.ready <= 1'b1;
                    SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:     out_ch.ready <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    // hang guard
    initial
    begin : watchdog
        #2000000;
        $display("keyed_top_k_score_table: mismatch");
        $finish;
    end

endmodule

### files.f
rtl/ktk_pkg.sv
rtl/ktk_in_if.sv
rtl/ktk_out_if.sv
rtl/ktk_cell.sv
rtl/keyed_top_k_score_table.sv
tb/tb_keyed_top_k_score_table.sv
